[rtl/brsb_pkg.sv]
// Package for the bilinear RGB565 shade and blend core.
// Holds constants, the request kinds, register indexes and colour helper functions.
package brsb_pkg;

    localparam int MaxSide   = 128;
    localparam int SideW     = $clog2(MaxSide);
    localparam int AddrW     = 2 * SideW;
    localparam int HalfSide  = MaxSide / 2;
    localparam int HalfW     = $clog2(HalfSide);
    localparam int BankAddrW = 2 * HalfW;
    localparam int BankDepth = HalfSide * HalfSide;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb8_t;

    function automatic rgb8_t unpack565(input logic [15:0] c);
        rgb8_t o;
        o.r = {c[15:11], c[15:13]};
        o.g = {c[10:5], c[10:9]};
        o.b = {c[4:0], c[4:2]};
        return o;
    endfunction

    function automatic logic [15:0] pack565(input rgb8_t c);
        return {c.r[7:3], c.g[7:2], c.b[7:3]};
    endfunction

    // a + floor((b - a) * f / 256)
    function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] f);
        logic signed [17:0] p;
        logic signed [9:0]  s;
        p = $signed({1'b0, a, 8'd0}) + ($signed({1'b0, b}) - $signed({1'b0, a}))
            * $signed({1'b0, f});
        s = p[17:8];
        return s[7:0];
    endfunction

    function automatic logic [7:0] shade8(input logic [7:0] c, input logic [8:0] s);
        logic [16:0] p;
        p = c * s;
        return (p[16:8] > 9'd255) ? 8'd255 : p[15:8];
    endfunction

    function automatic logic [7:0] blend8(input logic [7:0] f, input logic [7:0] bgc,
                                          input logic [7:0] a);
        logic [16:0] p;
        p = f * a + bgc * (9'd256 - {1'b0, a});
        return p[15:8];
    endfunction

endpackage

[rtl/brsb_texstore.sv]
// Texture store split in four banks by column and row parity.
// One write port and one read per bank each cycle; uses brsb_pkg.
module brsb_texstore
    import brsb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [1:0]           wr_bank,
    input  logic [BankAddrW-1:0] wr_addr,
    input  logic [15:0]          wr_data,
    input  logic                 rd_en,
    input  logic [BankAddrW-1:0] rd_addr [4],
    output logic [15:0]          rd_data [4]
);
    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [15:0] mem [BankDepth];
        always_ff @(posedge aclk) begin
            if (wr_en && wr_bank == 2'(k)) begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en) begin
                rd_data[k] <= mem[rd_addr[k]];
            end
        end
    end
endmodule

[rtl/brsb_colour.sv]
// Colour pipeline: bilinear or nearest filter, shade, blend, three register stages.
// Takes the four texels after the store read and reorder registers; uses brsb_pkg.
module brsb_colour
    import brsb_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [15:0] tex [4],
    input  logic        nearest,
    input  logic [1:0]  sel,
    input  logic [7:0]  fx,
    input  logic [7:0]  fy,
    input  logic [8:0]  shade,
    input  logic [7:0]  alpha,
    input  logic [15:0] bg,
    output logic [15:0] pixel
);
    // Stage 1: horizontal interpolation.
    rgb8_t row0_reg, row1_reg;
    logic  [15:0] near_reg, bg1_reg, bg2_reg;
    logic  nearest1_reg;
    logic  [7:0] fy_reg, alpha1_reg, alpha2_reg;
    logic  [8:0] shade_reg;
    logic  [15:0] col2_reg;

    rgb8_t c00, c10, c01, c11, r0, r1, v;
    logic [15:0] col, sh;
    rgb8_t s, bl;

    always_comb begin
        c00 = unpack565(tex[0]);
        c10 = unpack565(tex[1]);
        c01 = unpack565(tex[2]);
        c11 = unpack565(tex[3]);
        r0.r = lerp8(c00.r, c10.r, fx);
        r0.g = lerp8(c00.g, c10.g, fx);
        r0.b = lerp8(c00.b, c10.b, fx);
        r1.r = lerp8(c01.r, c11.r, fx);
        r1.g = lerp8(c01.g, c11.g, fx);
        r1.b = lerp8(c01.b, c11.b, fx);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            row0_reg     <= r0;
            row1_reg     <= r1;
            near_reg     <= tex[sel];
            nearest1_reg <= nearest;
            fy_reg       <= fy;
            shade_reg    <= shade;
            alpha1_reg   <= alpha;
            bg1_reg      <= bg;
        end
    end

    // Stage 2: vertical interpolation and shade.
    always_comb begin
        v.r = lerp8(row0_reg.r, row1_reg.r, fy_reg);
        v.g = lerp8(row0_reg.g, row1_reg.g, fy_reg);
        v.b = lerp8(row0_reg.b, row1_reg.b, fy_reg);
        col = nearest1_reg ? near_reg : pack565(v);
        s   = unpack565(col);
        s.r = shade8(s.r, shade_reg);
        s.g = shade8(s.g, shade_reg);
        s.b = shade8(s.b, shade_reg);
        sh  = (shade_reg == 9'd256) ? col : pack565(s);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            col2_reg   <= sh;
            alpha2_reg <= alpha1_reg;
            bg2_reg    <= bg1_reg;
        end
    end

    // Stage 3: blend over the background.
    rgb8_t f, b;
    always_comb begin
        f    = unpack565(col2_reg);
        b    = unpack565(bg2_reg);
        bl.r = blend8(f.r, b.r, alpha2_reg);
        bl.g = blend8(f.g, b.g, alpha2_reg);
        bl.b = blend8(f.b, b.b, alpha2_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pixel <= (alpha2_reg == 8'd255) ? col2_reg : pack565(bl);
        end
    end
endmodule

[rtl/bilinear_rgb565_shade_blend_core.sv]
// Top level of the bilinear RGB565 shade and blend core.
// Uses brsb_pkg, brsb_texstore and brsb_colour.
//
//  channel | direction | payload
//  s_      | in        | tuser kind, tdata address/texel/coords/shade/alpha/background
//  m_      | out       | tdata pixel_out
//  cfg_    | in        | index, data
//
// One request per cycle unless the output stalls. A sample request passes
// through address generation and store read, quad reorder and three colour
// stages. The pipeline moves as a whole and halts while its last stage holds
// a result not yet taken. Writes land in the store in the accept cycle, so a
// later sample sees them. Reset is synchronous; the store is not cleared.
module bilinear_rgb565_shade_blend_core
    import brsb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,   // kind
    // texel_address[13:0], texel_value[29:14], coord_x[53:30], coord_y[77:54],
    // shade_level[86:78], blend_alpha[94:87], background_pixel[110:95]
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // pixel_out
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data
);
    logic [7:0] width_reg, height_reg;
    logic       mode_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 8'd128;
            height_reg <= 8'd128;
            mode_reg   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_MODE:   mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Valid bits of the five stages.
    logic [4:0] vld_reg;
    logic       adv;
    assign adv      = !vld_reg[4] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[4];

    logic acc;
    assign acc = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[3:0], acc && s_tuser == KIND_SAMPLE};
        end
    end

    // Coordinate clamp and address generation.
    logic [SideW:0]   w, h;
    logic signed [23:0] cx, cy;
    logic [SideW-1:0] sx, sy, sx1, sy1;
    logic [7:0]       fx, fy;

    function automatic logic [SideW:0] side_of(input logic [7:0] r);
        if (r == 8'd0) return (SideW+1)'(1);
        if ({1'b0, r} > 9'(MaxSide)) return (SideW+1)'(MaxSide);
        return (SideW+1)'(r);
    endfunction

    function automatic logic [23:0] clampq(input logic signed [23:0] v,
                                           input logic [SideW:0] side);
        logic signed [24:0] hi;
        hi = $signed({1'b0, 8'(side - 1'b1), 16'd0});
        if (v < 0) return 24'd0;
        if ($signed({v[23], v}) > hi) return hi[23:0];
        return v;
    endfunction

    logic [23:0] qx, qy;
    always_comb begin
        w   = side_of(width_reg);
        h   = side_of(height_reg);
        cx  = $signed(s_tdata[53:30]);
        cy  = $signed(s_tdata[77:54]);
        qx  = clampq(cx, w);
        qy  = clampq(cy, h);
        sx  = qx[16 +: SideW];
        sy  = qy[16 +: SideW];
        fx  = qx[15:8];
        fy  = qy[15:8];
        sx1 = ({1'b0, sx} + 1'b1 < w) ? sx + 1'b1 : sx;
        sy1 = ({1'b0, sy} + 1'b1 < h) ? sy + 1'b1 : sy;
    end

    // Bank k = {row parity, column parity}; each bank holds one of each quad.
    // On the last column or row both entries of a pair carry the same texel.
    logic [SideW-1:0]     colb [2];
    logic [SideW-1:0]     rowb [2];
    logic [BankAddrW-1:0] rd_addr [4];
    always_comb begin
        colb[0]      = sx;
        colb[1]      = sx;
        rowb[0]      = sy;
        rowb[1]      = sy;
        colb[sx[0]]  = sx;
        colb[sx1[0]] = sx1;
        rowb[sy[0]]  = sy;
        rowb[sy1[0]] = sy1;
        rd_addr[0]   = {rowb[0][SideW-1:1], colb[0][SideW-1:1]};
        rd_addr[1]   = {rowb[0][SideW-1:1], colb[1][SideW-1:1]};
        rd_addr[2]   = {rowb[1][SideW-1:1], colb[0][SideW-1:1]};
        rd_addr[3]   = {rowb[1][SideW-1:1], colb[1][SideW-1:1]};
    end

    logic [AddrW-1:0] wa;
    logic             wr_en;
    assign wa    = s_tdata[AddrW-1:0];
    assign wr_en = acc && s_tuser == KIND_WRITE;

    logic [15:0] bank_q [4];
    brsb_texstore u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_bank ({wa[SideW], wa[0]}),
        .wr_addr ({wa[AddrW-1:SideW+1], wa[SideW-1:1]}),
        .wr_data (s_tdata[29:14]),
        .rd_en   (adv),
        .rd_addr (rd_addr),
        .rd_data (bank_q)
    );

    // Side data held while the banks are read.
    logic [1:0]  p00_reg, p10_reg, p01_reg, p11_reg;
    logic        mode1_reg;
    logic [7:0]  fx_reg, fy_reg, alpha_reg;
    logic [8:0]  shade_reg;
    logic [15:0] bg_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            p00_reg   <= {sy[0],  sx[0]};
            p10_reg   <= {sy[0],  sx1[0]};
            p01_reg   <= {sy1[0], sx[0]};
            p11_reg   <= {sy1[0], sx1[0]};
            mode1_reg <= mode_reg;
            fx_reg    <= fx;
            fy_reg    <= fy;
            shade_reg <= s_tdata[86:78];
            alpha_reg <= s_tdata[94:87];
            bg_reg    <= s_tdata[110:95];
        end
    end

    // A quad fetch and its reorder stage before the colour pipe.
    logic [15:0] tex_reg [4];
    logic        mode2_reg;
    logic [7:0]  fx2_reg, fy2_reg, alpha2_reg;
    logic [8:0]  shade2_reg;
    logic [15:0] bg2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            tex_reg[0] <= bank_q[p00_reg];
            tex_reg[1] <= bank_q[p10_reg];
            tex_reg[2] <= bank_q[p01_reg];
            tex_reg[3] <= bank_q[p11_reg];
            mode2_reg  <= mode1_reg;
            fx2_reg    <= fx_reg;
            fy2_reg    <= fy_reg;
            shade2_reg <= shade_reg;
            alpha2_reg <= alpha_reg;
            bg2_reg    <= bg_reg;
        end
    end

    brsb_colour u_colour (
        .aclk    (aclk),
        .en      (adv),
        .tex     (tex_reg),
        .nearest (mode2_reg),
        .sel     (2'd0),
        .fx      (fx2_reg),
        .fy      (fy2_reg),
        .shade   (shade2_reg),
        .alpha   (alpha2_reg),
        .bg      (bg2_reg),
        .pixel   (m_tdata)
    );
endmodule

[rtl/brsb_checker.sv]
// Port-level checker for the shade and blend core, bound to the top level.
// Depends on the top level's ports only.
module brsb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request refused with empty output");
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !$isunknown(m_tdata))
        else $error("result pixel has unknown bits");
endmodule

bind bilinear_rgb565_shade_blend_core brsb_checker u_brsb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
